/* rtl/hmpq_pkg.sv */
// Shared types for the max-heap priority queue: request and response
// payload structs and the status codes. No dependencies.
`default_nettype none

package hmpq_pkg;

  // Width of one stored key
  localparam int unsigned KeyW = 32;
  // Width of the reported entry count
  localparam int unsigned CountOutW = 7;

  // Request action codes
  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_EXTRACT = 1'b1
  } action_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One input request
  typedef struct packed {
    action_e                  action;
    logic signed [KeyW-1:0]   key_value;
  } req_t;

  // One response
  typedef struct packed {
    logic signed [KeyW-1:0]   out_value;
    status_e                  status;
    logic [CountOutW-1:0]     count_after;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/hmpq_ram.sv */
// Heap key store: one write port and two read ports, read data registered.
// Depends on hmpq_pkg for the key width.
`default_nettype none

module hmpq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [AW-1:0]                    waddr_i,
  input  wire logic signed [hmpq_pkg::KeyW-1:0] wdata_i,
  input  wire logic [AW-1:0]                    raddr_a_i,
  input  wire logic [AW-1:0]                    raddr_b_i,
  output logic signed [hmpq_pkg::KeyW-1:0]      rdata_a_o,
  output logic signed [hmpq_pkg::KeyW-1:0]      rdata_b_o
);

  logic [hmpq_pkg::KeyW-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two entries into registered outputs
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/max_heap_priority_queue_unit.sv */
// Binary max-heap priority queue over a one-based key store in a RAM.
// Rejects go straight to the response. An insert climbs level by level and
// stops below a parent that is not smaller; an extract of the last key skips
// the sift down, else the moved key sinks level by level.
// One request at a time: the next can be accepted as soon as the response is valid.
// Reset clears the entry count and control; the store is not cleared.
`default_nettype none

module max_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hmpq_pkg::req_t   in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hmpq_pkg::rsp_t        out_rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP_RD   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_DN_LOAD = 7'b0001000,
    S_DN_RD   = 7'b0010000,
    S_DN_CMP  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e                             state_q, state_d;
  logic [CW-1:0]                      count_q, count_d;
  logic [CW-1:0]                      pos_q, pos_d;
  logic signed [hmpq_pkg::KeyW-1:0]   val_q, val_d;
  logic signed [hmpq_pkg::KeyW-1:0]   res_value_q, res_value_d;
  hmpq_pkg::status_e                  res_status_q, res_status_d;
  logic                               out_valid_q, out_valid_d;
  hmpq_pkg::rsp_t                     out_q, out_d;

  logic                               we;
  logic [AW-1:0]                      waddr;
  logic signed [hmpq_pkg::KeyW-1:0]   wdata;
  logic [AW-1:0]                      raddr_a, raddr_b;
  logic signed [hmpq_pkg::KeyW-1:0]   rdata_a, rdata_b;

  logic [CW:0]                        left_pos;
  logic [CW:0]                        count_ext;
  logic                               left_ok, right_ok;
  logic                               take_left, take_right;
  logic signed [hmpq_pkg::KeyW-1:0]   left_best;

  // Map a one-based position to a store index
  function automatic logic [AW-1:0] pos2idx(input logic [CW:0] p);
    logic [CW:0] diff;
    diff = p - (CW+1)'(1);
    return diff[AW-1:0];
  endfunction

  hmpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Child selection for sift down: left wins ties, strict compare only
  assign left_pos   = {pos_q, 1'b0};
  assign count_ext  = {1'b0, count_q};
  assign left_ok    = (left_pos <= count_ext);
  assign right_ok   = ((left_pos + (CW+1)'(1)) <= count_ext);
  assign take_left  = left_ok && (rdata_a > val_q);
  assign left_best  = take_left ? rdata_a : val_q;
  assign take_right = right_ok && (rdata_b > left_best);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Sequencer: read, compare, move the hole, write back
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    we           = 1'b0;
    waddr        = pos2idx({1'b0, pos_q});
    wdata        = val_q;
    raddr_a      = pos2idx({2'b0, pos_q[CW-1:1]});
    raddr_b      = pos2idx({1'b0, count_q});

    // Drop a response once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        raddr_a = pos2idx((CW+1)'(1));
        raddr_b = pos2idx({1'b0, count_q});
        if (in_valid_i) begin
          res_value_d  = '0;
          res_status_d = hmpq_pkg::ST_OK;
          if (in_req_i.action == hmpq_pkg::ACT_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = hmpq_pkg::ST_FULL;
              state_d      = S_FINISH;
            end else begin
              count_d = count_q + CW'(1);
              pos_d   = count_q + CW'(1);
              val_d   = in_req_i.key_value;
              state_d = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = hmpq_pkg::ST_EMPTY;
              state_d      = S_FINISH;
            end else begin
              state_d = S_DN_LOAD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == CW'(1)) begin
          we      = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (val_q > rdata_a) begin
          wdata   = rdata_a;
          pos_d   = {1'b0, pos_q[CW-1:1]};
          state_d = S_UP_RD;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_DN_LOAD: begin
        res_value_d = rdata_a;
        val_d       = rdata_b;
        count_d     = count_q - CW'(1);
        pos_d       = CW'(1);
        if (count_q == CW'(1)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_DN_RD;
        end
      end

      S_DN_RD: begin
        raddr_a = pos2idx(left_pos);
        raddr_b = left_pos[AW-1:0];
        if (!left_ok) begin
          we      = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata   = rdata_b;
          pos_d   = left_pos[CW-1:0] + CW'(1);
          state_d = S_DN_RD;
        end else if (take_left) begin
          wdata   = rdata_a;
          pos_d   = left_pos[CW-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.out_value   = res_value_q;
          out_d.status      = res_status_q;
          out_d.count_after = hmpq_pkg::CountOutW'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for max_heap_priority_queue_unit: drives insert and extract requests
// and checks every response against a behavioral max-heap held in the bench.
// Depends on hmpq_pkg and the RTL of the queue unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CAPACITY = 64;
  // Slowest request: one level per log2 step, plus overhead
  localparam int DrainCycles = 2 * $clog2(CAPACITY) + 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hmpq_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hmpq_pkg::rsp_t out_rsp;

  // Bench copy of the heap, one-based like the block
  logic signed [hmpq_pkg::KeyW-1:0] heap_keys [1:CAPACITY];
  int unsigned heap_count = 0;

  // Responses still owed by the block, oldest first
  hmpq_pkg::rsp_t pending_rsp_q[$];
  int mismatch_count = 0;

  // Idle control shared by sender and receiver
  bit idling_on = 1'b1;
  int hold_request = 0;

  max_heap_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #16_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Full-range keys, narrow windows that force ties, and the extremes
  function automatic logic signed [hmpq_pkg::KeyW-1:0] random_key();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 8)) - 4;
      7:          return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      8:          return 32'sh8000_0000 + $urandom_range(0, 3);
      default:    return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
    endcase
  endfunction

  // Apply one request to the bench heap and return the response it owes
  function automatic hmpq_pkg::rsp_t heap_apply(hmpq_pkg::req_t req);
    hmpq_pkg::rsp_t rsp;
    int pos;
    int par;
    int lft;
    int rgt;
    int best;
    logic signed [hmpq_pkg::KeyW-1:0] tmp;
    rsp = '0;
    rsp.status = hmpq_pkg::ST_OK;
    if (req.action == hmpq_pkg::ACT_INSERT) begin
      if (heap_count >= CAPACITY) begin
        rsp.status = hmpq_pkg::ST_FULL;
      end else begin
        heap_count++;
        heap_keys[heap_count] = req.key_value;
        pos = heap_count;
        // Climb while strictly greater than the parent
        while (pos > 1) begin
          par = pos / 2;
          if (!(heap_keys[pos] > heap_keys[par])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[par];
          heap_keys[par] = tmp;
          pos = par;
        end
      end
    end else begin
      if (heap_count == 0) begin
        rsp.status = hmpq_pkg::ST_EMPTY;
      end else begin
        rsp.out_value = heap_keys[1];
        heap_keys[1] = heap_keys[heap_count];
        heap_count--;
        pos = 1;
        // Sink the moved entry; left child wins ties
        while (pos < heap_count) begin
          lft = 2 * pos;
          rgt = lft + 1;
          best = pos;
          if (lft <= heap_count && heap_keys[lft] > heap_keys[best]) best = lft;
          if (rgt <= heap_count && heap_keys[rgt] > heap_keys[best]) best = rgt;
          if (best == pos) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end
    rsp.count_after = heap_count[hmpq_pkg::CountOutW-1:0];
    return rsp;
  endfunction

  // Offer one request, hold it until accepted, then record what it owes
  task automatic send_request(input hmpq_pkg::action_e act,
                              input logic signed [hmpq_pkg::KeyW-1:0] key);
    hmpq_pkg::req_t req;
    int gap;
    req.action = act;
    req.key_value = key;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp_q.push_back(heap_apply(req));
  endtask

  // Hold the sender until every owed response is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic check_response(input hmpq_pkg::rsp_t got);
    hmpq_pkg::rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      $error("out_rsp: response with no request pending (out_value %0d status %0d)",
             got.out_value, got.status);
      mismatch_count++;
      return;
    end
    want = pending_rsp_q.pop_front();
    if (got.out_value !== want.out_value) begin
      $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.count_after !== want.count_after) begin
      $error("count_after: expected %0d, actual %0d", want.count_after, got.count_after);
      mismatch_count++;
    end
  endtask

  // Receiver: check each accepted response, then choose the next ready level
  initial begin
    int stall_left;
    bit next_ready;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_response(out_rsp);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && idling_on && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        next_ready = 1'b0;
        stall_left--;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Extract from an empty heap, with a key that must be ignored
  task automatic test_empty_extract();
    send_request(hmpq_pkg::ACT_EXTRACT, 32'sh1234_5678);
    send_request(hmpq_pkg::ACT_EXTRACT, -32'sh1);
  endtask

  // Insert the key extremes, then drain past empty
  task automatic test_key_extremes();
    send_request(hmpq_pkg::ACT_INSERT, 32'sh0);
    send_request(hmpq_pkg::ACT_INSERT, 32'sh8000_0000);
    send_request(hmpq_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    send_request(hmpq_pkg::ACT_INSERT, -32'sh1);
    send_request(hmpq_pkg::ACT_INSERT, 32'sh1);
    repeat (6) send_request(hmpq_pkg::ACT_EXTRACT, $urandom);
  endtask

  // Equal keys at several levels
  task automatic test_equal_keys();
    send_request(hmpq_pkg::ACT_INSERT, 32'sd5);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd5);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd5);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd3);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd5);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd7);
    send_request(hmpq_pkg::ACT_INSERT, 32'sd7);
    repeat (4) send_request(hmpq_pkg::ACT_EXTRACT, 32'sh0);
  endtask

  // Phases of differing insert bias walk the heap between empty and full
  task automatic test_random_mix(input int n_items);
    int issued;
    int phase_len;
    int insert_pct;
    hmpq_pkg::action_e act;
    issued = 0;
    while (issued < n_items) begin
      phase_len = $urandom_range(10, 120);
      case ($urandom_range(0, 4))
        0:       insert_pct = 90;
        1:       insert_pct = 65;
        2:       insert_pct = 50;
        3:       insert_pct = 35;
        default: insert_pct = 10;
      endcase
      repeat (phase_len) begin
        act = ($urandom_range(0, 99) < insert_pct) ? hmpq_pkg::ACT_INSERT
                                                   : hmpq_pkg::ACT_EXTRACT;
        send_request(act, random_key());
        issued++;
      end
    end
  endtask

  // Fill past capacity so inserts get rejected, then drain past empty
  task automatic test_fill_drain();
    repeat (CAPACITY + 4) send_request(hmpq_pkg::ACT_INSERT, random_key());
    repeat (CAPACITY + 4) send_request(hmpq_pkg::ACT_EXTRACT, random_key());
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task automatic test_backpressure();
    bit saved;
    saved = idling_on;
    idling_on = 1'b0;
    hold_request = 400;
    repeat (16) send_request(hmpq_pkg::ACT_INSERT, random_key());
    idling_on = saved;
  endtask

  initial begin
    apply_reset();
    test_empty_extract();
    test_key_extremes();
    test_equal_keys();
    test_random_mix(600);
    test_backpressure();
    test_random_mix(500);
    wait_drained();
    test_fill_drain();
    // Run a stretch with no idling on either side
    idling_on = 1'b0;
    test_random_mix(300);
    idling_on = 1'b1;
    test_random_mix(250);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
